/* hdl/sun_raster_stream_decoder_defines.svh */
// Assertion macros used by the checker file of the raster stream decoder.
`ifndef SUN_RASTER_STREAM_DECODER_DEFINES_SVH
`define SUN_RASTER_STREAM_DECODER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define SRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/srd_pkg.sv */
// Package with the shared types and constants of the raster stream decoder.
`timescale 1ns / 1ps
package srd_pkg;
  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned MapBytes    = 768;
  localparam int unsigned DimBitsDef  = 16;
  localparam int unsigned MapAddrBits = 10;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_HEADER = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_MAP    = 3'd2,
    PH_PIXELS = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // Work handed from the front parser to the back end.
  typedef struct packed {
    status_e     status;
    logic        lookup;
    logic [7:0]  index;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic        last_in_row;
    logic        last_in_image;
  } job_t;

  // Color table write from the front parser.
  typedef struct packed {
    logic                   en;
    logic [MapAddrBits-1:0] addr;
    logic [7:0]             data;
  } map_wr_t;
endpackage

/* hdl/srd_front.sv */
// Front parser: header, color map bytes and pixel assembly.
`timescale 1ns / 1ps
module srd_front #(
  parameter int unsigned DimBits = srd_pkg::DimBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_of_image_i,
  output logic                job_valid_o,
  output srd_pkg::job_t       job_o,
  output srd_pkg::map_wr_t    map_wr_o,
  output logic [srd_pkg::MapAddrBits-1:0] map_loaded_o
);
  import srd_pkg::*;

  phase_e              phase_q, phase_d, ph;
  logic [4:0]          hcnt_q, hcnt_d;
  logic [31:0]         hshift_q, hshift_d, sh;
  logic [DimBits-1:0]  width_q, width_d, height_q, height_d;
  logic [DimBits-1:0]  col_q, col_d, row_q, row_d;
  logic [2:0]          bpp_q, bpp_d, bpp;
  logic [31:0]         mleft_q, mleft_d, mleft;
  logic [MapAddrBits:0] mload_q, mload_d, mload;
  logic [23:0]         pix_q, pix_d;
  logic [1:0]          bip_q, bip_d;
  logic                pad_q, pad_d, bad_q, bad_d, bad;
  logic [DimBits-1:0]  w, h;
  logic                lr, li;

  assign map_loaded_o = (mload_q > (MapAddrBits+1)'(MapBytes)) ?
                        MapAddrBits'(MapBytes) : mload_q[MapAddrBits-1:0];

  // Next-state logic for the whole parse.
  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; hshift_d = hshift_q;
    width_d = width_q; height_d = height_q; bpp_d = bpp_q;
    mleft_d = mleft_q; mload_d = mload_q; pix_d = pix_q; bip_d = bip_q;
    col_d = col_q; row_d = row_q; pad_d = pad_q; bad_d = bad_q;
    job_valid_o = 1'b0; job_o = '0; map_wr_o = '0;
    ph = phase_q; w = width_q; h = height_q; bpp = bpp_q; bad = bad_q;
    mleft = mleft_q; mload = mload_q; sh = '0; lr = 1'b0; li = 1'b0;
    if (valid_i) begin
      if (start_of_image_i) begin
        ph = PH_HEADER; hcnt_d = '0; w = '0; h = '0; bpp = '0; bad = 1'b0;
        mleft = '0; mload = '0; pix_d = '0; bip_d = '0; col_d = '0;
        row_d = '0; pad_d = 1'b0;
        sh = {24'd0, data_byte_i};
      end else begin
        sh = {hshift_q[23:0], data_byte_i};
      end
      phase_d = ph; width_d = w; height_d = h; bpp_d = bpp; bad_d = bad;
      mleft_d = mleft; mload_d = mload;
      unique case (ph)
        PH_HEADER: begin
          hshift_d = sh;
          if (hcnt_d[1:0] == 2'd3) begin
            case (hcnt_d[4:2])
              3'd1: begin
                if (sh[31:DimBits] != '0) bad_d = 1'b1;
                width_d = sh[DimBits-1:0];
              end
              3'd2: begin
                if (sh[31:DimBits] != '0) bad_d = 1'b1;
                height_d = sh[DimBits-1:0];
              end
              3'd3: bpp_d = (sh == 32'd32) ? 3'd4 : (sh == 32'd24) ? 3'd3 :
                            (sh == 32'd8) ? 3'd1 : 3'd0;
              3'd7: mleft_d = sh;
              default: ;
            endcase
          end
          if (hcnt_d != 5'(HeaderBytes - 1)) begin
            hcnt_d = hcnt_d + 5'd1;
          end else begin
            hcnt_d = '0;
            job_valid_o = 1'b1;
            if (bad_d || bpp_d == 3'd0) begin
              phase_d = PH_IDLE;
              job_o.status = ST_ERROR;
            end else begin
              mload_d = '0;
              job_o.status = ST_HEADER;
              job_o.has_alpha = (bpp_d == 3'd4);
              if (mleft_d != '0) phase_d = PH_MAP;
              else if (width_d == '0 || height_d == '0) phase_d = PH_DONE;
              else phase_d = PH_PIXELS;
            end
          end
        end
        PH_MAP: begin
          if (mload < (MapAddrBits+1)'(MapBytes)) begin
            map_wr_o.en = 1'b1;
            map_wr_o.addr = mload[MapAddrBits-1:0];
            map_wr_o.data = data_byte_i;
            mload_d = mload + 1'b1;
          end
          mleft_d = mleft - 32'd1;
          if (mleft_d == '0)
            phase_d = (w == '0 || h == '0) ? PH_DONE : PH_PIXELS;
        end
        PH_PIXELS: begin
          if (pad_d) begin
            pad_d = 1'b0;
          end else begin
            case (bip_d)
              2'd0: pix_d[7:0] = data_byte_i;
              2'd1: pix_d[15:8] = data_byte_i;
              2'd2: pix_d[23:16] = data_byte_i;
              default: ;
            endcase
            if (3'(bip_d) + 3'd1 < bpp) begin
              bip_d = bip_d + 2'd1;
            end else begin
              bip_d = '0;
              lr = ((DimBits+1)'(col_d) + 1'b1 >= (DimBits+1)'(w));
              li = lr && ((DimBits+1)'(row_d) + 1'b1 >= (DimBits+1)'(h));
              job_valid_o = 1'b1;
              job_o.status = ST_PIXEL;
              job_o.lookup = (bpp == 3'd1);
              job_o.index = pix_d[7:0];
              // The third byte is red and the first is blue.
              job_o.rgb = pix_d;
              job_o.alpha = (bpp == 3'd4) ? data_byte_i : 8'd255;
              job_o.has_alpha = (bpp == 3'd4);
              job_o.last_in_row = lr;
              job_o.last_in_image = li;
              if (lr) begin
                col_d = '0;
                row_d = row_d + 1'b1;
                if (w[0] & bpp[0]) pad_d = 1'b1;
                if (li) phase_d = PH_DONE;
              end else begin
                col_d = col_d + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; hcnt_q <= '0; hshift_q <= '0; width_q <= '0;
      height_q <= '0; bpp_q <= '0; mleft_q <= '0; mload_q <= '0;
      pix_q <= '0; bip_q <= '0; col_q <= '0; row_q <= '0;
      pad_q <= 1'b0; bad_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; hshift_q <= hshift_d;
      width_q <= width_d; height_q <= height_d; bpp_q <= bpp_d;
      mleft_q <= mleft_d; mload_q <= mload_d; pix_q <= pix_d;
      bip_q <= bip_d; col_q <= col_d; row_q <= row_d;
      pad_q <= pad_d; bad_q <= bad_d;
    end
  end
endmodule

/* hdl/srd_back.sv */
// Back end: color table, lookup stage and result queue.
`timescale 1ns / 1ps
module srd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  srd_pkg::job_t    job_i,
  input  srd_pkg::map_wr_t map_wr_i,
  input  logic [srd_pkg::MapAddrBits-1:0] map_loaded_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output srd_pkg::job_t    head_o
);
  import srd_pkg::*;

  localparam int unsigned Slots   = QueueDepth + 2;
  localparam int unsigned Entries = MapBytes / 3;

  logic [7:0]             mem_r [Entries];
  logic [7:0]             mem_g [Entries];
  logic [7:0]             mem_b [Entries];
  logic [7:0]             rd_r_q, rd_g_q, rd_b_q;
  logic                   stg_v_q;
  job_t                   stg_q;
  logic [MapAddrBits-1:0] lim_q;
  logic [1:0]             wch_q, wch_d, wch;
  logic [7:0]             widx_q, widx_d, widx;
  job_t                   fifo_q [Slots];
  logic [1:0]             wp_q, rp_q;
  logic [2:0]             cnt_q, cnt_d;
  job_t                   res;
  logic                   push, pop;

  // Map bytes arrive in order from entry 0; each goes to the bank of its channel.
  always_comb begin
    wch    = (map_wr_i.addr == '0) ? 2'd0 : wch_q;
    widx   = (map_wr_i.addr == '0) ? 8'd0 : widx_q;
    wch_d  = wch_q;
    widx_d = widx_q;
    if (map_wr_i.en) begin
      if (wch == 2'd2) begin
        wch_d  = 2'd0;
        widx_d = widx + 8'd1;
      end else begin
        wch_d  = wch + 2'd1;
        widx_d = widx;
      end
    end
  end

  // Red bank: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (map_wr_i.en && wch == 2'd0) mem_r[widx] <= map_wr_i.data;
    rd_r_q <= mem_r[job_i.index];
  end

  // Green bank: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (map_wr_i.en && wch == 2'd1) mem_g[widx] <= map_wr_i.data;
    rd_g_q <= mem_g[job_i.index];
  end

  // Blue bank: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (map_wr_i.en && wch == 2'd2) mem_b[widx] <= map_wr_i.data;
    rd_b_q <= mem_b[job_i.index];
  end

  // Lookup stage payload.
  always_ff @(posedge clk_i) begin
    lim_q <= map_loaded_i;
    stg_q <= job_i;
  end

  // Stage valid and map write position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0; wch_q <= '0; widx_q <= '0;
    end else begin
      stg_v_q <= job_valid_i;
      wch_q <= wch_d;
      widx_q <= widx_d;
    end
  end

  // Resolve a lookup: loaded entries from memory, the rest the gray ramp.
  always_comb begin
    logic [MapAddrBits-1:0] e;
    e = MapAddrBits'({stg_q.index, 1'b0}) + MapAddrBits'(stg_q.index);
    res = stg_q;
    if (stg_q.lookup) begin
      res.rgb[23:16] = (e < lim_q) ? rd_r_q : stg_q.index;
      res.rgb[15:8]  = (e + 1'b1 < lim_q) ? rd_g_q : stg_q.index;
      res.rgb[7:0]   = (e + 2'd2 < lim_q) ? rd_b_q : stg_q.index;
    end
  end

  // Result queue; room for the items in flight keeps the stage drain-free.
  assign push    = stg_v_q;
  assign pop     = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q >= 3'(QueueDepth)) ;
  assign head_o  = fifo_q[rp_q];
  assign cnt_d   = cnt_q + 3'(push) - 3'(pop);

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end
endmodule

/* hdl/sun_raster_stream_decoder.sv */
// A result passes through the lookup stage register and then the result queue before it can be popped.
// Throughput: one byte per cycle while full is low; the table read stage is pipelined.
// full rises with two results waiting, leaving room for the one in flight.
// Reset (rst_ni low, asynchronous) idles the parser and empties the queue.
// Color table contents are not cleared; unloaded entries read as gray.
`timescale 1ns / 1ps
module sun_raster_stream_decoder #(
  parameter int unsigned DimBits = srd_pkg::DimBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_image_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       has_alpha_o,
  output logic       last_in_row_o,
  output logic       last_in_image_o
);
  import srd_pkg::*;

  logic                   job_valid;
  job_t                   job, head;
  map_wr_t                map_wr;
  logic [MapAddrBits-1:0] map_loaded;

  srd_front #(.DimBits(DimBits)) u_front (
    .clk_i, .rst_ni, .valid_i(push && !full), .data_byte_i, .start_of_image_i,
    .job_valid_o(job_valid), .job_o(job), .map_wr_o(map_wr),
    .map_loaded_o(map_loaded)
  );

  srd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .map_wr_i(map_wr),
    .map_loaded_i(map_loaded), .full_o(full), .pop_i(pop), .empty_o(empty),
    .head_o(head)
  );

  assign status_o        = head.status;
  assign red_o           = head.rgb[23:16];
  assign green_o         = head.rgb[15:8];
  assign blue_o          = head.rgb[7:0];
  assign alpha_o         = head.alpha;
  assign has_alpha_o     = head.has_alpha;
  assign last_in_row_o   = head.last_in_row;
  assign last_in_image_o = head.last_in_image;
endmodule

/* hdl/srd_checker.sv */
// Port-level checker for the raster stream decoder, with its bind.
`timescale 1ns / 1ps
module srd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status_o,
  input logic [7:0] red_o,
  input logic [7:0] alpha_o,
  input logic       has_alpha_o,
  input logic       last_in_row_o,
  input logic       last_in_image_o
);
  import srd_pkg::*;
  `include "sun_raster_stream_decoder_defines.svh"

  `SRD_ASSERT_IMP(a_no_bad_status, clk_i, rst_ni, !empty, status_o != 2'd3)
  `SRD_ASSERT_IMP(a_last_img_row, clk_i, rst_ni, !empty && last_in_image_o, last_in_row_o)
  `SRD_ASSERT_IMP(a_err_zero, clk_i, rst_ni, !empty && status_o == ST_ERROR, red_o == 8'd0 && !has_alpha_o)
  `SRD_ASSERT_IMP(a_alpha_def, clk_i, rst_ni, !empty && status_o == ST_PIXEL && !has_alpha_o, alpha_o == 8'd255)
  `SRD_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty)
endmodule

bind sun_raster_stream_decoder srd_checker u_srd_checker (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .red_o, .alpha_o,
  .has_alpha_o, .last_in_row_o, .last_in_image_o
);
